@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define FBFL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication, checked on every rising edge outside reset
`define FBFL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define FBFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fbfl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbfl_pkg
// types, widths and codes shared by the block free-list allocator
// ----------------------------------------------------------------------------
package fbfl_pkg;

    localparam int NUM_BLOCKS  = 256;
    localparam int MAX_POOL    = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
    localparam int LINK_AW     = $clog2(NUM_BLOCKS);
    localparam int IDX_W       = 8;
    localparam int CNT_W       = 9;
    localparam int BYTES_W     = 13;
    localparam int STRIDE_W    = 13;
    localparam int OFFSET_W    = 20;
    localparam int PROD_W      = IDX_W + STRIDE_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 40;

    localparam int MAX_BLOCK_BYTES = 4096;
    localparam int HEADER_BYTES    = 24;
    localparam int TAG_BYTES       = 8;
    localparam int RESET_STRIDE    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // one finished list operation, handed on for offset calculation
    typedef struct packed {
        logic [IDX_W-1:0] gidx;
        logic             grant;
        status_t          status;
        logic [CNT_W-1:0] count;
    } fbfl_req_t;

endpackage

@@ src/fbfl_ram.sv @@
// ----------------------------------------------------------------------------
// fbfl_ram
// generic single-port ram, registered read
// ----------------------------------------------------------------------------
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/fbfl_list.sv @@
// ----------------------------------------------------------------------------
// fbfl_list
// free-list sequencer: link memory, recycled head, fresh counter, free count
// ----------------------------------------------------------------------------
module fbfl_list (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  fbfl_pkg::cmd_t                  in_cmd,
    input  logic [fbfl_pkg::IDX_W-1:0]      in_index,
    input  logic                            cfg_we,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            req_valid,
    input  logic                            req_ready,
    output fbfl_pkg::fbfl_req_t             req
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LINK = 3'b010,
        S_HAND = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic [fbfl_pkg::IDX_W-1:0]       head_reg, head_next;
    logic                             rvalid_reg, rvalid_next;
    logic [fbfl_pkg::CNT_W-1:0]       fresh_reg, fresh_next;
    logic [fbfl_pkg::CNT_W-1:0]       free_reg, free_next;
    logic [fbfl_pkg::CNT_W-1:0]       pool_reg, pool_next;
    fbfl_pkg::fbfl_req_t              req_reg, req_next;

    logic                             accept;
    logic [fbfl_pkg::CNT_W-1:0]       untouched;
    logic [fbfl_pkg::CNT_W-1:0]       recycled;
    logic [fbfl_pkg::CNT_W-1:0]       pool_sat;
    logic                             mem_we;
    logic [fbfl_pkg::LINK_AW-1:0]     mem_addr;
    logic [fbfl_pkg::IDX_W-1:0]       mem_rdata;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign req_valid = (state_reg == S_HAND);
    assign req       = req_reg;

    assign untouched = pool_reg - fresh_reg;
    assign recycled  = (free_reg > untouched) ? (free_reg - untouched) : '0;

    // free pushes a link at the freed index, alloc reads the link behind the head
    assign mem_we   = accept && (in_cmd == fbfl_pkg::CMD_FREE)
                      && ({1'b0, in_index} < pool_reg);
    assign mem_addr = (in_cmd == fbfl_pkg::CMD_FREE) ? fbfl_pkg::LINK_AW'(in_index)
                                                     : fbfl_pkg::LINK_AW'(head_reg);

    fbfl_ram #(
        .WIDTH (fbfl_pkg::IDX_W),
        .DEPTH (fbfl_pkg::NUM_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (head_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        pool_sat = cfg_data[fbfl_pkg::CNT_W-1:0];
        if (pool_sat == '0)
        begin
            pool_sat = fbfl_pkg::CNT_W'(1);
        end
        else if (pool_sat > fbfl_pkg::CNT_W'(fbfl_pkg::MAX_POOL))
        begin
            pool_sat = fbfl_pkg::CNT_W'(fbfl_pkg::MAX_POOL);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        rvalid_next = rvalid_reg;
        fresh_next  = fresh_reg;
        free_next   = free_reg;
        pool_next   = pool_reg;
        req_next    = req_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next.gidx   = '0;
                    req_next.grant  = 1'b0;
                    req_next.status = fbfl_pkg::ST_OK;
                    state_next      = S_HAND;
                    if (in_cmd == fbfl_pkg::CMD_ALLOC)
                    begin
                        if (rvalid_reg)
                        begin
                            req_next.gidx  = head_reg;
                            req_next.grant = 1'b1;
                            rvalid_next    = (recycled > fbfl_pkg::CNT_W'(1));
                            if (free_reg != '0)
                            begin
                                free_next = free_reg - 1'b1;
                            end
                            state_next = S_LINK;
                        end
                        else if (fresh_reg < pool_reg)
                        begin
                            req_next.gidx  = fresh_reg[fbfl_pkg::IDX_W-1:0];
                            req_next.grant = 1'b1;
                            fresh_next     = fresh_reg + 1'b1;
                            if (free_reg != '0)
                            begin
                                free_next = free_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            req_next.status = fbfl_pkg::ST_EMPTY;
                        end
                    end
                    else
                    begin
                        if (mem_we)
                        begin
                            head_next   = in_index;
                            rvalid_next = 1'b1;
                            if (free_reg < pool_reg)
                            begin
                                free_next = free_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            req_next.status = fbfl_pkg::ST_RANGE;
                        end
                    end
                    req_next.count = free_next;
                end
            end
            S_LINK:
            begin
                head_next  = mem_rdata;
                state_next = S_HAND;
            end
            S_HAND:
            begin
                if (req_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pool size write restarts the pool
        if (cfg_we && (cfg_index == fbfl_pkg::CFG_POOL_BLOCKS))
        begin
            pool_next   = pool_sat;
            head_next   = '0;
            rvalid_next = 1'b0;
            fresh_next  = '0;
            free_next   = pool_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            rvalid_reg <= 1'b0;
            fresh_reg  <= '0;
            free_reg   <= fbfl_pkg::CNT_W'(fbfl_pkg::MAX_POOL);
            pool_reg   <= fbfl_pkg::CNT_W'(fbfl_pkg::MAX_POOL);
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            rvalid_reg <= rvalid_next;
            fresh_reg  <= fresh_next;
            free_reg   <= free_next;
            pool_reg   <= pool_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

endmodule

@@ src/fbfl_offset.sv @@
// ----------------------------------------------------------------------------
// fbfl_offset
// block stride register, offset multiply stage and output register
// ----------------------------------------------------------------------------
module fbfl_offset (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  fbfl_pkg::fbfl_req_t              req,
    input  logic                             cfg_we,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fbfl_pkg::OUT_DATA_W-1:0]  out_data
);

    logic [fbfl_pkg::STRIDE_W-1:0]    stride_reg;
    logic [fbfl_pkg::BYTES_W-1:0]     bytes_sat;
    logic [fbfl_pkg::BYTES_W-1:0]     bytes_pad;

    logic                             v1_reg;
    fbfl_pkg::fbfl_req_t              req1_reg;
    logic [fbfl_pkg::PROD_W-1:0]      prod_reg;
    logic                             move1;

    logic                             out_valid_reg;
    logic [fbfl_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic [fbfl_pkg::OFFSET_W-1:0]    offset;

    always_comb
    begin
        bytes_sat = cfg_data[fbfl_pkg::BYTES_W-1:0];
        if (bytes_sat == '0)
        begin
            bytes_sat = fbfl_pkg::BYTES_W'(1);
        end
        else if (bytes_sat > fbfl_pkg::BYTES_W'(fbfl_pkg::MAX_BLOCK_BYTES))
        begin
            bytes_sat = fbfl_pkg::BYTES_W'(fbfl_pkg::MAX_BLOCK_BYTES);
        end
        // round up to whole words
        bytes_pad = (bytes_sat + fbfl_pkg::BYTES_W'(7)) & ~fbfl_pkg::BYTES_W'(7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= fbfl_pkg::STRIDE_W'(fbfl_pkg::RESET_STRIDE);
        end
        else if (cfg_we && (cfg_index == fbfl_pkg::CFG_BLOCK_BYTES))
        begin
            stride_reg <= bytes_pad + fbfl_pkg::STRIDE_W'(fbfl_pkg::TAG_BYTES);
        end
    end

    assign move1     = v1_reg && (!out_valid_reg || out_ready);
    assign req_ready = !v1_reg || move1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                v1_reg <= req_valid;
            end
            if (move1)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req1_reg <= req;
            prod_reg <= req.grant ? (fbfl_pkg::PROD_W'(req.gidx) * fbfl_pkg::PROD_W'(stride_reg))
                                  : '0;
        end
        if (move1)
        begin
            out_data_reg <= {1'b0, req1_reg.count, req1_reg.status, offset, req1_reg.gidx};
        end
    end

    // header, then the tag word in front of the user data
    assign offset = req1_reg.grant
                    ? fbfl_pkg::OFFSET_W'(prod_reg
                        + fbfl_pkg::PROD_W'(fbfl_pkg::HEADER_BYTES + fbfl_pkg::TAG_BYTES))
                    : '0;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/fixed_block_free_list_allocator_top.sv @@
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// fixed-size block allocator with a last-in-first-out free list
// ----------------------------------------------------------------------------
// Hands out and takes back blocks of a pool one item at a time. An allocate
// that reuses a freed block passes through the link state (the link memory
// read behind the list head) before the handoff state; other allocates, frees
// and refused items go straight to the handoff state. The result follows
// through a multiply stage and an output register, and a new item may enter
// while a result still waits. While m_tready stays low up to three items wait
// inside before s_tready stays low. The link memory needs no clearing after
// reset. Writing the pool size restarts the pool with every block free.
module fixed_block_free_list_allocator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fbfl_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] block_index
    input  logic [0:0]                      s_tuser,   // [0] cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] granted_index, [27:8] granted_offset, [29:28] status,
    // [38:30] free_count, [39] zero
    output logic [fbfl_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                 req_valid;
    logic                 req_ready;
    fbfl_pkg::fbfl_req_t  req;

    fbfl_list u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (fbfl_pkg::cmd_t'(s_tuser[0])),
        .in_index  (s_tdata[fbfl_pkg::IDX_W-1:0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    fbfl_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

@@ src/fbfl_checker.sv @@
// ----------------------------------------------------------------------------
// fbfl_checker
// port-level checks of the block allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbfl_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fbfl_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic [fbfl_pkg::IDX_W-1:0]    out_index;
    logic [fbfl_pkg::OFFSET_W-1:0] out_offset;
    logic [1:0]                    out_status;
    logic [fbfl_pkg::CNT_W-1:0]    out_count;
    logic                          refused;
    logic                          no_block;
    logic                          fields_ok;

    assign out_index  = m_tdata[7:0];
    assign out_offset = m_tdata[27:8];
    assign out_status = m_tdata[29:28];
    assign out_count  = m_tdata[38:30];

    assign refused   = m_tvalid && (out_status != fbfl_pkg::ST_OK);
    assign no_block  = (out_offset == '0) && (out_index == '0);
    assign fields_ok = (out_count <= fbfl_pkg::CNT_W'(fbfl_pkg::MAX_POOL))
                       && ((out_status == fbfl_pkg::ST_OK)
                           || (out_status == fbfl_pkg::ST_EMPTY)
                           || (out_status == fbfl_pkg::ST_RANGE));

    // held result stays put until taken
    `FBFL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held")

    // refused items carry no block
    `FBFL_ASSERT_IMPL(a_refused_empty, refused, no_block, "refused item carries a block")

    // offsets are whole words
    `FBFL_ASSERT_IMPL(a_offset_align, m_tvalid, out_offset[2:0] == 3'd0, "offset not aligned")

    // free count never exceeds the largest pool, status is a known code
    `FBFL_ASSERT_IMPL(a_count_range, m_tvalid, fields_ok, "free count or status out of range")

endmodule

bind fixed_block_free_list_allocator_top fbfl_checker u_fbfl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
